FILE: src/lppp_pkg.sv
// shared constants and types for the lidar point pinhole projection unit
package lppp_pkg;

	localparam int PT_W   = 24;   // input coordinate width, q16.8
	localparam int ROT_W  = 16;   // rotation entry width, q2.14
	localparam int TR_W   = 20;   // translation width, q12.8
	localparam int F_W    = 24;   // focal / center width, q20.4
	localparam int PIX_W  = 24;   // pixel output width
	localparam int ST_W   = 2;    // status width
	localparam int PRD_W  = PT_W + ROT_W;           // rotation product width
	localparam int CAM_W  = 42;                     // camera coordinate width, q.22
	localparam int MAG_W  = CAM_W;                  // magnitude width
	localparam int HALF_W = MAG_W / 2;              // magnitude split for multiply
	localparam int PP_W   = HALF_W + F_W;           // partial product width
	localparam int PROD_W = MAG_W + F_W;            // full product width
	localparam int DEN_W  = CAM_W + 1;              // doubled depth width
	localparam int Q_W    = 27;                     // quotient bits produced
	localparam int REM_W  = DEN_W + Q_W;            // divider remainder width
	localparam int NDIV   = Q_W;                    // divider stages, one bit each
	localparam int NST    = NDIV + 6;               // total pipeline stages
	localparam int TSH    = 14;                     // translation alignment shift

	localparam logic [Q_W-1:0] QCLAMP = Q_W'(1 << 25);
	localparam int PIX_MAX = (1 << (PIX_W - 1)) - 1;
	localparam int PIX_MIN = -(1 << (PIX_W - 1));

	localparam logic [47:0] ROT0_RST  = 48'd16384;
	localparam logic [47:0] ROT1_RST  = 48'd16384 << 16;
	localparam logic [47:0] ROT2_RST  = 48'd16384 << 32;
	localparam logic [47:0] FOCAL_RST = (48'd16000 << 24) | 48'd16000;

	typedef enum logic [2:0] {
		REG_ROT0   = 3'd0,
		REG_ROT1   = 3'd1,
		REG_ROT2   = 3'd2,
		REG_TRANS  = 3'd3,
		REG_FOCAL  = 3'd4,
		REG_CENTER = 3'd5
	} reg_idx_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_DEPTH = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

endpackage

FILE: src/lidar_point_pinhole_projection_unit.sv
// top level: pipelined pinhole projection of lidar points to pixel coordinates
//
// Takes one lidar point (x, y, z, signed q16.8 metres) per transfer on the s_ side and gives
// one pixel result (u, v signed q20.4, saturated, plus a status) per point on the m_ side,
// in order. The unit accepts one point every clock cycle unless a stalled output has filled
// the pipeline. A point passes through rotation products, sums, split focal multiply, dividend
// setup, a 27-stage restoring divider (one quotient bit per stage) and the final clamp stage.
// Each stage holds its item until the next stage is free, so bubbles collapse and, while any
// stage is empty, the input keeps flowing as a finished result waits at the output. Status 1
// means depth not positive (u = v = 0), status 2 means u or v was clamped. Registers are written
// through the cfg_ channel (always ready) and must only change while no point is in flight.
module lidar_point_pinhole_projection_unit
	import lppp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_data,
	// point input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // pt_x [23:0], pt_y [47:24], pt_z [71:48]
	// pixel output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // pix_u [23:0], pix_v [47:24], status [49:48], zero fill
);

	// configuration registers
	logic [47:0] rot_q [3];
	logic [59:0] trans_q;
	logic [47:0] focal_q;
	logic [47:0] center_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= ROT0_RST;
			rot_q[1] <= ROT1_RST;
			rot_q[2] <= ROT2_RST;
			trans_q  <= '0;
			focal_q  <= FOCAL_RST;
			center_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROT0:   rot_q[0] <= cfg_data[47:0];
				REG_ROT1:   rot_q[1] <= cfg_data[47:0];
				REG_ROT2:   rot_q[2] <= cfg_data[47:0];
				REG_TRANS:  trans_q  <= cfg_data;
				REG_FOCAL:  focal_q  <= cfg_data[47:0];
				REG_CENTER: center_q <= cfg_data[47:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// stage valids and advance chain: a stage moves when it is empty or its successor moves
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || m_tready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign s_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= s_tvalid;
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// stage 1: nine rotation products
	logic signed [PRD_W-1:0] prd_s1 [3][3];
	logic signed [PT_W-1:0]  pt [3];

	assign pt[0] = $signed(s_tdata[23:0]);
	assign pt[1] = $signed(s_tdata[47:24]);
	assign pt[2] = $signed(s_tdata[71:48]);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prd_s1[r][c] <= $signed(rot_q[r][ROT_W*c +: ROT_W]) * pt[c];
				end
			end
		end
	end

	// stage 2: camera frame point, rows plus aligned translation
	logic signed [CAM_W-1:0] cam_s2 [3];
	logic [TR_W-1:0]         tr [3];

	assign tr[0] = trans_q[19:0];
	assign tr[1] = trans_q[39:20];
	assign tr[2] = trans_q[59:40];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int r = 0; r < 3; r++) begin
				cam_s2[r] <= CAM_W'(prd_s1[r][0]) + CAM_W'(prd_s1[r][1]) + CAM_W'(prd_s1[r][2])
					+ $signed({{(CAM_W-TR_W-TSH){tr[r][TR_W-1]}}, tr[r], {TSH{1'b0}}});
			end
		end
	end

	// stage 3: sign split and focal partial products
	logic [PP_W-1:0]  pl_s3 [2];
	logic [PP_W-1:0]  ph_s3 [2];
	logic             neg_s3 [2];
	logic             zpos_s3;
	logic [CAM_W-1:0] z_s3;
	logic [MAG_W-1:0] mag [2];
	logic [F_W-1:0]   fl [2];

	assign fl[0] = focal_q[23:0];
	assign fl[1] = focal_q[47:24];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			mag[j] = cam_s2[j][CAM_W-1] ? MAG_W'(-cam_s2[j]) : MAG_W'(cam_s2[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int j = 0; j < 2; j++) begin
				pl_s3[j]  <= PP_W'(mag[j][HALF_W-1:0]) * PP_W'(fl[j]);
				ph_s3[j]  <= PP_W'(mag[j][MAG_W-1:HALF_W]) * PP_W'(fl[j]);
				neg_s3[j] <= cam_s2[j][CAM_W-1];
			end
			zpos_s3 <= !cam_s2[2][CAM_W-1] && (cam_s2[2] != '0);
			z_s3    <= cam_s2[2];
		end
	end

	// stage 4: full product
	logic [PROD_W-1:0] prod_s4 [2];
	logic              neg_s4 [2];
	logic              zpos_s4;
	logic [CAM_W-1:0]  z_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int j = 0; j < 2; j++) begin
				prod_s4[j] <= PROD_W'(pl_s3[j]) + (PROD_W'(ph_s3[j]) << HALF_W);
				neg_s4[j]  <= neg_s3[j];
			end
			zpos_s4 <= zpos_s3;
			z_s4    <= z_s3;
		end
	end

	// stage 5: rounding dividend 2*prod + z over divisor 2*z, early overflow check
	logic [REM_W-1:0] rem_s5 [2];
	logic [DEN_W-1:0] d_s5;
	logic             ovf_s5 [2];
	logic             neg_s5 [2];
	logic             zpos_s5;
	logic [REM_W-1:0] num [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			num[j] = REM_W'({prod_s4[j], 1'b0}) + REM_W'(z_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int j = 0; j < 2; j++) begin
				rem_s5[j] <= num[j];
				ovf_s5[j] <= num[j] >= (REM_W'({z_s4, 1'b0}) << Q_W);
				neg_s5[j] <= neg_s4[j];
			end
			d_s5    <= {z_s4, 1'b0};
			zpos_s5 <= zpos_s4;
		end
	end

	// stages 6..: restoring divider, one quotient bit per stage, msb first
	logic [REM_W-1:0] rem_s6 [NDIV][2];
	logic [Q_W-1:0]   q_s6   [NDIV][2];
	logic             ovf_s6 [NDIV][2];
	logic             neg_s6 [NDIV][2];
	logic [DEN_W-1:0] d_s6   [NDIV];
	logic             zpos_s6 [NDIV];

	// divider chain view: entry 0 is the setup stage, entry k+1 is divider stage k
	logic [REM_W-1:0] rem_c  [NDIV+1][2];
	logic [Q_W-1:0]   q_c    [NDIV+1][2];
	logic             ovf_c  [NDIV+1][2];
	logic             neg_c  [NDIV+1][2];
	logic [DEN_W-1:0] d_c    [NDIV+1];
	logic             zpos_c [NDIV+1];

	logic [REM_W-1:0] rem_nx [NDIV][2];
	logic [Q_W-1:0]   q_nx   [NDIV][2];
	logic [REM_W-1:0] dsh    [NDIV];

	always_comb begin
		d_c[0]    = d_s5;
		zpos_c[0] = zpos_s5;
		for (int j = 0; j < 2; j++) begin
			rem_c[0][j] = rem_s5[j];
			q_c[0][j]   = '0;
			ovf_c[0][j] = ovf_s5[j];
			neg_c[0][j] = neg_s5[j];
		end
		for (int k = 0; k < NDIV; k++) begin
			d_c[k+1]    = d_s6[k];
			zpos_c[k+1] = zpos_s6[k];
			for (int j = 0; j < 2; j++) begin
				rem_c[k+1][j] = rem_s6[k][j];
				q_c[k+1][j]   = q_s6[k][j];
				ovf_c[k+1][j] = ovf_s6[k][j];
				neg_c[k+1][j] = neg_s6[k][j];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NDIV; k++) begin
			dsh[k] = REM_W'(d_c[k]) << (Q_W - 1 - k);
			for (int j = 0; j < 2; j++) begin
				if (rem_c[k][j] >= dsh[k]) begin
					rem_nx[k][j] = rem_c[k][j] - dsh[k];
					q_nx[k][j]   = {q_c[k][j][Q_W-2:0], 1'b1};
				end else begin
					rem_nx[k][j] = rem_c[k][j];
					q_nx[k][j]   = {q_c[k][j][Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NDIV; k++) begin
			if (adv[5+k]) begin
				d_s6[k]    <= d_c[k];
				zpos_s6[k] <= zpos_c[k];
				for (int j = 0; j < 2; j++) begin
					rem_s6[k][j] <= rem_nx[k][j];
					q_s6[k][j]   <= q_nx[k][j];
					ovf_s6[k][j] <= ovf_c[k][j];
					neg_s6[k][j] <= neg_c[k][j];
				end
			end
		end
	end

	// final stage: clamp quotient, apply sign, add principal point, saturate
	logic signed [PIX_W-1:0] pix_s7 [2];
	status_t                 st_s7;
	logic [Q_W-1:0]          qc   [2];
	logic signed [Q_W:0]     sq   [2];
	logic signed [Q_W+1:0]   sum  [2];
	logic signed [PIX_W-1:0] pix  [2];
	logic                    sat  [2];
	logic signed [F_W-1:0]   cc   [2];

	assign cc[0] = $signed(center_q[23:0]);
	assign cc[1] = $signed(center_q[47:24]);

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			if (ovf_s6[NDIV-1][j] || (q_s6[NDIV-1][j] > QCLAMP)) qc[j] = QCLAMP;
			else qc[j] = q_s6[NDIV-1][j];
			sq[j]  = neg_s6[NDIV-1][j] ? -$signed({1'b0, qc[j]}) : $signed({1'b0, qc[j]});
			sum[j] = (Q_W+2)'(sq[j]) + (Q_W+2)'(cc[j]);
			if (sum[j] > (Q_W+2)'(PIX_MAX)) begin
				pix[j] = PIX_W'(PIX_MAX);
				sat[j] = 1'b1;
			end else if (sum[j] < (Q_W+2)'(PIX_MIN)) begin
				pix[j] = PIX_W'(PIX_MIN);
				sat[j] = 1'b1;
			end else begin
				pix[j] = sum[j][PIX_W-1:0];
				sat[j] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			if (!zpos_s6[NDIV-1]) begin
				// depth not positive wins over saturation
				pix_s7[0] <= '0;
				pix_s7[1] <= '0;
				st_s7     <= ST_DEPTH;
			end else begin
				pix_s7[0] <= pix[0];
				pix_s7[1] <= pix[1];
				st_s7     <= (sat[0] || sat[1]) ? ST_SAT : ST_OK;
			end
		end
	end

	assign m_tvalid = vld_q[NST-1];
	assign m_tdata  = {6'b0, st_s7, pix_s7[1], pix_s7[0]};

	// checks
	a_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[49:48] == ST_DEPTH) |-> (m_tdata[47:0] == '0))
		else $error("depth fault result carries nonzero pixels");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[49:48] != 2'd3))
		else $error("undefined status code");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_out_moves: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NST-2] && !m_tvalid |=> m_tvalid)
		else $error("finished item did not reach output stage");

endmodule
